/* rtl/core/decade_bucket_min_max_count_defines.svh */
// Assertion macros shared by the statistics block.
`ifndef DECADE_BUCKET_MIN_MAX_COUNT_DEFINES_SVH
`define DECADE_BUCKET_MIN_MAX_COUNT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DBMMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DBMMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dbmmc_pkg.sv */
package dbmmc_pkg;

    localparam int NUM_BUCKETS_DEF = 9;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int VALUE_W  = 7;
    localparam int INDEX_W  = 4;
    localparam int MIN_W    = 10;
    localparam int MAX_W    = 7;
    localparam int COUNT_W  = 16;

    localparam logic [MIN_W-1:0]   EMPTY_MIN  = 10'd999;
    localparam logic [VALUE_W-1:0] LOW_VALUE  = 7'd10;
    localparam logic [VALUE_W-1:0] HIGH_VALUE = 7'd99;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } req_op_t;

    typedef struct packed {
        req_op_t              op;
        logic [INDEX_W-1:0]   bucket;
        logic [VALUE_W-1:0]   value;
        logic                 err;
    } cmd_t;

    typedef struct packed {
        logic [MIN_W-1:0]     min;
        logic [MAX_W-1:0]     max;
        logic [COUNT_W-1:0]   count;
        logic                 err;
    } result_t;

    // floor(v / 10) for v below 128, by reciprocal multiply (205 / 2048)
    function automatic logic [INDEX_W-1:0] decade_of(input logic [VALUE_W-1:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * 15'd205;
        return prod[14:11];
    endfunction

endpackage

/* rtl/core/decade_bucket_min_max_count.sv */
// A request accepted into the command queue goes through the combinational
// back end, which holds it while the result queue is full, and its result is
// registered into the result queue. Throughput: one request per cycle when the
// result queue is not full; each add read-modify-writes one bucket register.
// Reset (rst_n, asynchronous): every bucket minimum goes to 999, maximum and
// count to 0, and both queues empty.
`include "decade_bucket_min_max_count_defines.svh"

module decade_bucket_min_max_count
    import dbmmc_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [VALUE_W-1:0] sample_value,
    input  logic [INDEX_W-1:0] bucket_index,
    output logic               empty,
    input  logic               pop,
    output logic [MIN_W-1:0]   bucket_min,
    output logic [MAX_W-1:0]   bucket_max,
    output logic [COUNT_W-1:0] bucket_count,
    output logic               error_status
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

    cmd_t    cmd_in, cmd_out;
    result_t res_in, res_out;
    logic    cmd_empty, cmd_pop;
    logic    res_full, res_push;

    dbmmc_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .req_type     (req_type),
        .sample_value (sample_value),
        .bucket_index (bucket_index),
        .cmd          (cmd_in)
    );

    dbmmc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    dbmmc_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .res_full  (res_full),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_in)
    );

    dbmmc_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign bucket_min   = res_out.min;
    assign bucket_max   = res_out.max;
    assign bucket_count = res_out.count;
    assign error_status = res_out.err;

    `DBMMC_ASSERT_NOW(a_err_zero, !empty && error_status, bucket_min == '0 && bucket_max == '0 && bucket_count == '0, "rejected request carries nonzero statistics")
    `DBMMC_ASSERT_NOW(a_min_le_max, !empty && !error_status && bucket_min != EMPTY_MIN, bucket_min <= 10'(bucket_max) && bucket_max <= HIGH_VALUE, "bucket minimum above maximum")
    `DBMMC_ASSERT_NEXT(a_cmd_drain, !cmd_empty && !res_full, cmd_empty || !full, "command queue stuck full while back end free")

endmodule

/* rtl/core/dbmmc_queue.sv */
module dbmmc_queue
    import dbmmc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/dbmmc_front.sv */
module dbmmc_front
    import dbmmc_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic               req_type,
    input  logic [VALUE_W-1:0] sample_value,
    input  logic [INDEX_W-1:0] bucket_index,
    output cmd_t               cmd
);

    logic [INDEX_W-1:0] decade;
    logic [INDEX_W-1:0] add_bucket;
    logic               add_err;
    logic               read_err;

    assign decade     = decade_of(sample_value);
    assign add_bucket = decade - 1'b1;
    assign add_err    = (sample_value < LOW_VALUE) || (sample_value > HIGH_VALUE) ||
                        (add_bucket >= INDEX_W'(NUM_BUCKETS));
    assign read_err   = (bucket_index >= INDEX_W'(NUM_BUCKETS));

    always_comb
    begin
        cmd.op    = req_op_t'(req_type);
        cmd.value = sample_value;
        case (req_op_t'(req_type))
            OP_ADD:
            begin
                cmd.bucket = add_bucket;
                cmd.err    = add_err;
            end
            OP_READ:
            begin
                cmd.bucket = bucket_index;
                cmd.err    = read_err;
            end
            default:
            begin
                cmd.bucket = bucket_index;
                cmd.err    = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/dbmmc_back.sv */
module dbmmc_back
    import dbmmc_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    input  logic    res_full,
    output logic    cmd_pop,
    output logic    res_push,
    output result_t res
);

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    logic [MIN_W-1:0]      min_reg   [NUM_BUCKETS];
    logic [MAX_W-1:0]      max_reg   [NUM_BUCKETS];
    logic [COUNT_BITS-1:0] count_reg [NUM_BUCKETS];

    logic                  fire;
    logic                  is_add;
    logic [NUM_BUCKETS-1:0] hit;
    logic [MIN_W-1:0]      cur_min, min_next;
    logic [MAX_W-1:0]      cur_max, max_next;
    logic [COUNT_BITS-1:0] cur_count, count_next;
    logic [31:0]           count_wide;

    assign fire     = cmd_valid && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;
    assign is_add   = (cmd.op == OP_ADD);

    always_comb
    begin
        cur_min   = '0;
        cur_max   = '0;
        cur_count = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            hit[i] = !cmd.err && (cmd.bucket == INDEX_W'(i));
            if (hit[i])
            begin
                cur_min   = min_reg[i];
                cur_max   = max_reg[i];
                cur_count = count_reg[i];
            end
        end
    end

    always_comb
    begin
        min_next   = cur_min;
        max_next   = cur_max;
        count_next = cur_count;
        if (is_add)
        begin
            if ({3'd0, cmd.value} < cur_min)
            begin
                min_next = {3'd0, cmd.value};
            end
            if (cmd.value > cur_max)
            begin
                max_next = cmd.value;
            end
            if (cur_count != COUNT_LIMIT)
            begin
                count_next = cur_count + 1'b1;
            end
        end
        count_wide = 32'(count_next);
    end

    always_comb
    begin
        if (cmd.err)
        begin
            res = '{min: '0, max: '0, count: '0, err: 1'b1};
        end
        else
        begin
            res = '{min: min_next, max: max_next, count: count_wide[COUNT_W-1:0], err: 1'b0};
        end
    end

    // update the addressed bucket on an accepted add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                min_reg[i]   <= EMPTY_MIN;
                max_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                if (fire && is_add && hit[i])
                begin
                    min_reg[i]   <= min_next;
                    max_reg[i]   <= max_next;
                    count_reg[i] <= count_next;
                end
            end
        end
    end

endmodule

/* bench/decade_bucket_min_max_count_tb.sv */
module decade_bucket_min_max_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbmmc_pkg::*;

    localparam int DECADE      = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_REQS = 500;
    localparam int FLOOD_REQS  = 20;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    typedef struct {
        req_op_t            op;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] bucket;
        bit                 drain;
    } stat_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               req_type = 1'b0;
    logic [VALUE_W-1:0] sample_value = '0;
    logic [INDEX_W-1:0] bucket_index = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [MIN_W-1:0]   bucket_min;
    logic [MAX_W-1:0]   bucket_max;
    logic [COUNT_W-1:0] bucket_count;
    logic               error_status;

    stat_req_t pending_reqs[$];
    result_t   expected_stats[$];

    // bucket statistics as the block should hold them
    logic [MIN_W-1:0]          lowest [NUM_BUCKETS_DEF];
    logic [MAX_W-1:0]          highest[NUM_BUCKETS_DEF];
    logic [COUNT_BITS_DEF-1:0] tally  [NUM_BUCKETS_DEF];

    logic req_fire = 1'b0;
    logic res_fire = 1'b0;
    bit   flood = 1'b0;
    int   send_gap = 0;
    int   take_gap = 0;
    int   sent_reqs = 0;
    int   taken_results = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;

    decade_bucket_min_max_count u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .sample_value (sample_value),
        .bucket_index (bucket_index),
        .empty        (empty),
        .pop          (pop),
        .bucket_min   (bucket_min),
        .bucket_max   (bucket_max),
        .bucket_count (bucket_count),
        .error_status (error_status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Alternate stretches of random waits with stretches of none.
    function automatic int pick_wait(input int n);
        if (flood || (n / 40) % 3 == 1)
        begin
            return 0;
        end
        return $urandom_range(16, 0);
    endfunction

    function automatic result_t apply_request(input req_op_t op,
                                              input logic [VALUE_W-1:0] value,
                                              input logic [INDEX_W-1:0] bucket);
        result_t r;
        int      b;
        r = '0;
        r.err = 1'b1;
        if (op == OP_ADD)
        begin
            if (value < LOW_VALUE || value > HIGH_VALUE)
            begin
                return r;
            end
            b = int'(value) / DECADE - 1;
            if (b >= NUM_BUCKETS_DEF)
            begin
                return r;
            end
            if (tally[b] != COUNT_MAX)
            begin
                tally[b] = tally[b] + 1'b1;
            end
            if (value > highest[b])
            begin
                highest[b] = value;
            end
            if (value < lowest[b])
            begin
                lowest[b] = value;
            end
        end
        else
        begin
            if (bucket >= NUM_BUCKETS_DEF)
            begin
                return r;
            end
            b = int'(bucket);
        end
        r.min   = lowest[b];
        r.max   = highest[b];
        r.count = COUNT_W'(tally[b]);
        r.err   = 1'b0;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic queue_req(input req_op_t op, input int value, input int bucket,
                             input bit drain = 1'b0);
        stat_req_t r;
        r.op     = op;
        r.value  = VALUE_W'(value);
        r.bucket = INDEX_W'(bucket);
        r.drain  = drain;
        pending_reqs.push_back(r);
    endtask

    // request driver
    always @(negedge clk)
    begin
        stat_req_t cur;
        logic      next_push;
        next_push = push;
        if (!rst_n)
        begin
            next_push = 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                next_push = 1'b0;
            end
            if (!next_push && pending_reqs.size() != 0)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                end
                else if (!(pending_reqs[0].drain && expected_stats.size() != 0))
                begin
                    cur = pending_reqs.pop_front();
                    req_type     <= cur.op;
                    sample_value <= cur.value;
                    bucket_index <= cur.bucket;
                    next_push = 1'b1;
                    send_gap = pick_wait(sent_reqs);
                    sent_reqs++;
                end
            end
        end
        push <= next_push;
    end

    // result side stalls
    always @(negedge clk)
    begin
        logic next_pop;
        next_pop = pop;
        if (!rst_n)
        begin
            next_pop = 1'b0;
        end
        else
        begin
            if (res_fire)
            begin
                next_pop = 1'b0;
                take_gap = pick_wait(taken_results);
                taken_results++;
            end
            if (!next_pop)
            begin
                if (take_gap != 0)
                begin
                    take_gap--;
                end
                else
                begin
                    next_pop = 1'b1;
                end
            end
        end
        pop <= next_pop;
    end

    // monitor: check results, predict accepted requests, watch for a hang
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
            res_fire <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS_DEF; i++)
            begin
                lowest[i]  = EMPTY_MIN;
                highest[i] = '0;
                tally[i]   = '0;
            end
        end
        else
        begin
            req_fire <= push && !full;
            res_fire <= pop && !empty;
            if (pop && !empty)
            begin
                if (expected_stats.size() == 0)
                begin
                    flag_mismatch("result with no request outstanding", 0, 0);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (bucket_min !== want.min)
                        flag_mismatch("bucket_min", bucket_min, want.min);
                    if (bucket_max !== want.max)
                        flag_mismatch("bucket_max", bucket_max, want.max);
                    if (bucket_count !== want.count)
                        flag_mismatch("bucket_count", bucket_count, want.count);
                    if (error_status !== want.err)
                        flag_mismatch("error_status", error_status, want.err);
                end
            end
            if (push && !full)
            begin
                expected_stats.push_back(apply_request(req_op_t'(req_type), sample_value,
                                                       bucket_index));
            end
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int roll;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty buckets, then both rejected read indexes
        for (int i = 0; i < NUM_BUCKETS_DEF; i++)
        begin
            queue_req(OP_READ, $urandom_range(127, 0), i);
        end
        queue_req(OP_READ, 127, NUM_BUCKETS_DEF);
        queue_req(OP_READ, 0, 15);
        // range edges on both sides, rejected samples included
        queue_req(OP_ADD, 10, 15);
        queue_req(OP_ADD, 99, 0);
        queue_req(OP_ADD, 19, 0);
        queue_req(OP_ADD, 90, 15);
        queue_req(OP_ADD, 55, 7);
        queue_req(OP_ADD, 0, 0);
        queue_req(OP_ADD, 9, 15);
        queue_req(OP_ADD, 100, 3);
        queue_req(OP_ADD, 127, 15);
        queue_req(OP_READ, 0, 0);
        queue_req(OP_READ, 99, 4);
        queue_req(OP_READ, 10, 8);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 65)
                queue_req(OP_ADD, $urandom_range(99, 10), $urandom_range(15, 0),
                          i == 180 || i == 400);
            else if (roll < 75)
                queue_req(OP_ADD, $urandom_range(127, 0), $urandom_range(15, 0),
                          i == 180 || i == 400);
            else if (roll < 93)
                queue_req(OP_READ, $urandom_range(127, 0), $urandom_range(8, 0),
                          i == 180 || i == 400);
            else
                queue_req(OP_READ, $urandom_range(127, 0), $urandom_range(15, 0),
                          i == 180 || i == 400);
        end

        while (pending_reqs.size() != 0 || push || expected_stats.size() != 0)
            @(posedge clk);

        // hammer one bucket at full rate
        flood = 1'b1;
        for (int i = 0; i < FLOOD_REQS; i++)
        begin
            queue_req(OP_ADD, $urandom_range(69, 60), $urandom_range(15, 0));
        end
        queue_req(OP_ADD, 60, 0);
        queue_req(OP_ADD, 69, 0);
        for (int i = 0; i < NUM_BUCKETS_DEF; i++)
        begin
            queue_req(OP_READ, $urandom_range(127, 0), i);
        end

        while (pending_reqs.size() != 0 || push || expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
